// ===== rtl/core/pcb_pkg.sv =====
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared types and constants for the per-host circuit breaker table.
// ----------------------------------------------------------------------------
package pcb_pkg;

	// Request kinds, carried in the input tuser
	typedef enum logic [2:0] {
		FUNC_TICK         = 3'd0,
		FUNC_MAY_ANNOUNCE = 3'd1,
		FUNC_SENT         = 3'd2,
		FUNC_RESULT       = 3'd3,
		FUNC_BLOCKED_Q    = 3'd4,
		FUNC_CLEAR        = 3'd5
	} func_t;

	// Breaker modes
	typedef enum logic [1:0] {
		MODE_CLOSED = 2'd0,
		MODE_OPEN   = 2'd1,
		MODE_HALF   = 2'd2
	} mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MIN_STAGGER = 2'd0,
		CFG_MAX_STAGGER = 2'd1,
		CFG_BLOCK_DUR   = 2'd2,
		CFG_UDP_LIMIT   = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] MIN_STAGGER_RST = 16'd1;
	localparam logic [15:0] MAX_STAGGER_RST = 16'd5;
	localparam logic [15:0] BLOCK_DUR_RST   = 16'd360;
	localparam logic [7:0]  UDP_LIMIT_RST   = 8'd3;
	localparam logic [7:0]  RUN_MAX         = 8'hFF;

	typedef struct packed {
		logic        is_udp;
		logic        no_reply;
		logic        server_fault;
		logic        throttled;
		logic        success;
		logic [15:0] jitter;
		logic [5:0]  host_index;
		logic        host_present;
		func_t       func;
	} item_t;

	typedef struct packed {
		logic [15:0] min_stagger;
		logic [15:0] max_stagger;
		logic [15:0] block_duration;
		logic [7:0]  udp_timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic blocked;
		logic tripped;
		logic allowed;
	} res_t;

	// Side effects of one request on the table
	typedef struct packed {
		logic we;
		logic touch;
		logic clear;
		logic tick;
	} upd_ctl_t;

endpackage

// ===== rtl/core/pcb_ram.sv =====
// ----------------------------------------------------------------------------
// pcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/pcb_update.sv =====
// ----------------------------------------------------------------------------
// pcb_update
// Next-state and answer logic for one request on one breaker entry.
// ----------------------------------------------------------------------------
module pcb_update #(
	parameter int TIME_BITS = 32,
	localparam int ENTRY_W = 2 * TIME_BITS + 11
) (
	input  pcb_pkg::item_t       item,
	input  logic                 have,
	input  logic                 entry_valid,
	input  logic [ENTRY_W-1:0]   entry_rd,
	input  logic [TIME_BITS-1:0] time_now,
	input  pcb_pkg::cfg_t        cfg,
	output logic [ENTRY_W-1:0]   entry_wr,
	output logic [TIME_BITS-1:0] time_nxt,
	output pcb_pkg::res_t        res,
	output pcb_pkg::upd_ctl_t    ctl
);
	import pcb_pkg::*;

	typedef struct packed {
		mode_t                mode;
		logic                 probe;
		logic [7:0]           run;
		logic [TIME_BITS-1:0] next_slot;
		logic [TIME_BITS-1:0] reopen;
	} entry_t;

	entry_t      cur;
	entry_t      nxt;
	logic [15:0] span;
	logic [15:0] jit_clamped;
	logic [16:0] delay;
	logic [7:0]  run_inc;

	// Wrap-safe "now is before deadline"
	function automatic logic is_before(input logic [TIME_BITS-1:0] now,
	                                   input logic [TIME_BITS-1:0] dl);
		logic [TIME_BITS-1:0] diff;
		diff = now - dl;
		return diff[TIME_BITS-1];
	endfunction

	always_comb begin
		span        = (cfg.max_stagger >= cfg.min_stagger) ?
		              (cfg.max_stagger - cfg.min_stagger) : 16'd0;
		jit_clamped = (item.jitter < span) ? item.jitter : span;
		delay       = {1'b0, cfg.min_stagger} + {1'b0, jit_clamped};
	end

	always_comb begin
		if (entry_valid) begin
			cur = entry_t'(entry_rd);
		end else begin
			cur.mode      = MODE_CLOSED;
			cur.probe     = 1'b0;
			cur.run       = 8'd0;
			cur.next_slot = time_now;
			cur.reopen    = time_now;
		end
		run_inc  = (cur.run != RUN_MAX) ? cur.run + 8'd1 : cur.run;
		nxt      = cur;
		res      = '0;
		ctl      = '0;
		time_nxt = time_now;
		case (item.func)
			FUNC_TICK: begin
				ctl.tick = 1'b1;
				time_nxt = time_now + TIME_BITS'(1);
			end
			FUNC_MAY_ANNOUNCE: begin
				if (!have) begin
					res.allowed = 1'b1;
				end else begin
					ctl.we    = 1'b1;
					ctl.touch = 1'b1;
					if (cur.mode == MODE_OPEN && is_before(time_now, cur.reopen)) begin
						res.allowed = 1'b0;
					end else begin
						// expired open entry moves to half-open
						if (cur.mode == MODE_OPEN) begin
							nxt.mode  = MODE_HALF;
							nxt.probe = 1'b0;
						end
						if (nxt.mode == MODE_HALF) begin
							res.allowed = !nxt.probe;
						end else begin
							res.allowed = !is_before(time_now, cur.next_slot);
						end
					end
				end
			end
			FUNC_SENT: begin
				if (have) begin
					ctl.we    = 1'b1;
					ctl.touch = 1'b1;
					if (cur.mode == MODE_HALF) begin
						nxt.probe = 1'b1;
					end
					nxt.next_slot = time_now + TIME_BITS'(delay);
				end
			end
			FUNC_RESULT: begin
				if (have) begin
					ctl.we    = 1'b1;
					ctl.touch = 1'b1;
					if (item.success) begin
						nxt.run   = 8'd0;
						nxt.mode  = MODE_CLOSED;
						nxt.probe = 1'b0;
					end else if (cur.mode == MODE_HALF || item.throttled ||
					             item.server_fault ||
					             (item.no_reply && item.is_udp &&
					              run_inc >= cfg.udp_timeout_limit)) begin
						// trip the breaker
						nxt.mode    = MODE_OPEN;
						nxt.reopen  = time_now + TIME_BITS'(cfg.block_duration);
						nxt.run     = 8'd0;
						nxt.probe   = 1'b0;
						res.tripped = 1'b1;
					end else begin
						if (item.no_reply && item.is_udp) begin
							nxt.run = run_inc;
						end
						nxt.probe = 1'b0;
					end
				end
			end
			FUNC_BLOCKED_Q: begin
				res.blocked = have && entry_valid && cur.mode == MODE_OPEN &&
				              is_before(time_now, cur.reopen);
			end
			FUNC_CLEAR: begin
				ctl.clear = 1'b1;
			end
			default: begin
			end
		endcase
		entry_wr = nxt;
	end

endmodule

// ===== rtl/core/per_host_circuit_breaker_unit.sv =====
// ----------------------------------------------------------------------------
// per_host_circuit_breaker_unit
// Table of per-host circuit breakers (closed / open / half-open).
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: the request kind (tick, may-announce,
//   announce sent, result, blocked query, clear) in tuser, host and result
//   flags in tdata. Each request yields exactly one answer on m_axis.
//   Configuration is written on the cfg channel (always ready). The user must
//   write it only while the block is idle, which the block does not enforce.
//   Index 0 min stagger, 1 max stagger, 2 block duration, 3 UDP timeout limit.
//   A request is held in stage 1 while its entry is read; its answer is
//   registered in stage 2. Throughput: one request per cycle unless the
//   answer stalls, set by the single read-modify-write of the entry RAM; a
//   bypass register covers back-to-back requests to the same host.
//   Reset: time, valid bits, non-empty flag and registers return to their
//   defaults; entry contents are not cleared, a fresh entry is rebuilt on
//   first touch. Clear drops every entry by clearing the valid bits at once.
//   Stall: while m_axis_tready is low the answer holds, the stage behind it
//   holds and s_axis_tready drops once that stage is full.
// ----------------------------------------------------------------------------
module per_host_circuit_breaker_unit #(
	parameter int HOSTS     = 64,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata, low bit up: host_present, host_index[5:0], jitter[15:0], success,
	// throttled, server_fault, no_reply, is_udp, 4 bits zero
	input  logic [31:0] s_axis_tdata,
	// tuser: func[2:0]
	input  logic [2:0]  s_axis_tuser,
	// answer channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata, low bit up: allowed, tripped, blocked, table_nonempty, 4 bits zero
	output logic [7:0]  m_axis_tdata,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import pcb_pkg::*;

	localparam int AW      = (HOSTS > 1) ? $clog2(HOSTS) : 1;
	localparam int XW      = (AW > 6) ? AW : 6;
	localparam int ENTRY_W = 2 * TIME_BITS + 11;

	cfg_t                 cfg_q;
	logic [TIME_BITS-1:0] time_now_q;
	logic [HOSTS-1:0]     valid_q;
	logic                 nonempty_q;

	item_t                in_item;
	item_t                item_s1;
	logic                 valid_s1;
	res_t                 res_s2;
	logic                 nonempty_s2;
	logic                 valid_s2;

	logic                 s_accept;
	logic                 advance;
	logic [XW-1:0]        in_idx_x;
	logic [XW-1:0]        idx_x_s1;
	logic [AW-1:0]        in_addr;
	logic [AW-1:0]        addr_s1;
	logic [AW-1:0]        raddr;
	logic                 have_s1;
	logic                 ent_valid;

	logic [ENTRY_W-1:0]   ram_rdata;
	logic [ENTRY_W-1:0]   entry_rd;
	logic [ENTRY_W-1:0]   entry_wr;
	logic [TIME_BITS-1:0] time_nxt;
	res_t                 res;
	upd_ctl_t             ctl;
	logic                 nonempty_nxt;

	// bypass of the most recent entry write
	logic                 fwd_valid_q;
	logic [AW-1:0]        fwd_addr_q;
	logic [ENTRY_W-1:0]   fwd_data_q;

	// Unpack the request
	always_comb begin
		in_item.func         = func_t'(s_axis_tuser);
		in_item.host_present = s_axis_tdata[0];
		in_item.host_index   = s_axis_tdata[6:1];
		in_item.jitter       = s_axis_tdata[22:7];
		in_item.success      = s_axis_tdata[23];
		in_item.throttled    = s_axis_tdata[24];
		in_item.server_fault = s_axis_tdata[25];
		in_item.no_reply     = s_axis_tdata[26];
		in_item.is_udp       = s_axis_tdata[27];
	end

	// Handshake: stage 1 advances whenever the answer register is free or drains
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Host addressing
	assign in_idx_x  = XW'(in_item.host_index);
	assign idx_x_s1  = XW'(item_s1.host_index);
	assign in_addr   = in_idx_x[AW-1:0];
	assign addr_s1   = idx_x_s1[AW-1:0];
	assign have_s1   = item_s1.host_present && (32'(item_s1.host_index) < 32'(HOSTS));
	assign ent_valid = have_s1 && valid_q[addr_s1];

	// Read the incoming host on accept, otherwise re-read the held one
	assign raddr = s_accept ? in_addr : addr_s1;

	pcb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HOSTS)
	) u_ram (
		.clk  (clk),
		.we   (advance && ctl.we),
		.waddr(addr_s1),
		.wdata(entry_wr),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Take the bypass when the last write hit this host
	assign entry_rd = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : ram_rdata;

	pcb_update #(
		.TIME_BITS(TIME_BITS)
	) u_update (
		.item       (item_s1),
		.have       (have_s1),
		.entry_valid(ent_valid),
		.entry_rd   (entry_rd),
		.time_now   (time_now_q),
		.cfg        (cfg_q),
		.entry_wr   (entry_wr),
		.time_nxt   (time_nxt),
		.res        (res),
		.ctl        (ctl)
	);

	assign nonempty_nxt = ctl.clear ? 1'b0 : (nonempty_q | ctl.touch);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_stagger       <= MIN_STAGGER_RST;
			cfg_q.max_stagger       <= MAX_STAGGER_RST;
			cfg_q.block_duration    <= BLOCK_DUR_RST;
			cfg_q.udp_timeout_limit <= UDP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_STAGGER: cfg_q.min_stagger       <= cfg_data;
				CFG_MAX_STAGGER: cfg_q.max_stagger       <= cfg_data;
				CFG_BLOCK_DUR:   cfg_q.block_duration    <= cfg_data;
				CFG_UDP_LIMIT:   cfg_q.udp_timeout_limit <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Table control state: time, valid bits, non-empty flag, bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q  <= '0;
			valid_q     <= '0;
			nonempty_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else if (advance) begin
			time_now_q <= time_nxt;
			nonempty_q <= nonempty_nxt;
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (ctl.touch) begin
				valid_q[addr_s1] <= 1'b1;
			end
			if (ctl.we) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl.we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= entry_wr;
		end
	end

	// Stage 1: hold the request while the entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= in_item;
		end
	end

	// Stage 2: answer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2      <= res;
			nonempty_s2 <= nonempty_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, nonempty_s2, res_s2.blocked, res_s2.tripped,
	                        res_s2.allowed};

endmodule

// ===== rtl/core/pcb_checker.sv =====
// ----------------------------------------------------------------------------
// pcb_checker
// Port-level checks on the answer channel of the circuit breaker table.
// ----------------------------------------------------------------------------
module pcb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// No answer is offered while reset is held
	a_no_valid_in_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("answer valid during reset");

	// An answer carries at most one of allowed, tripped, blocked
	a_one_answer: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
		else $error("more than one answer flag set");

	// A trip or a block implies some entry exists
	a_trip_block_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[1] || m_axis_tdata[2])) |-> m_axis_tdata[3])
		else $error("trip or block reported on an empty table");

	// A stalled answer holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled answer changed");

endmodule

bind per_host_circuit_breaker_unit pcb_checker u_pcb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
